>>> sv/lrps_pkg.sv
// Package for the LRU page reference stack.
// Holds sizing constants and the control struct shared by the top level and the cells.
// No dependencies.
package lrps_pkg;

	localparam int DEPTH     = 8;
	localparam int PAGE_BITS = 16;
	localparam int CAP_BITS  = 4;
	localparam int OCC_BITS  = 4;
	localparam int CNT_BITS  = $clog2(DEPTH + 1);
	localparam int CMP_BITS  = (CNT_BITS > CAP_BITS) ? CNT_BITS : CAP_BITS;

	localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(8);

	// broadcast to every cell for one reference
	typedef struct packed {
		logic upd;    // reference accepted this cycle
		logic hit;    // key found somewhere in the stack
		logic evict;  // miss with the stack at or over capacity
	} cell_ctl_t;

endpackage

>>> sv/lrps_cell.sv
// One slot of the recency stack: page register, valid flag and local compare.
// Depends on lrps_pkg.
module lrps_cell import lrps_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cell_ctl_t            ctl,
	input  logic [PAGE_BITS-1:0] key,
	input  logic [PAGE_BITS-1:0] prev_page,
	input  logic                 prev_valid,
	input  logic                 match_in,
	input  logic                 next_valid,
	output logic [PAGE_BITS-1:0] page,
	output logic                 valid,
	output logic                 match_out,
	output logic [PAGE_BITS-1:0] tail_page
);

	logic [PAGE_BITS-1:0] page_q;
	logic                 valid_q;
	logic                 shift;

	assign match_out = match_in | (valid_q && (page_q == key));
	// last valid slot offers its page as the eviction candidate
	assign tail_page = (valid_q && !next_valid) ? page_q : '0;

	always_comb begin
		if (ctl.hit) begin
			shift = !match_in;
		end else if (ctl.evict) begin
			shift = valid_q;
		end else begin
			shift = valid_q | prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.upd && shift) begin
			page_q <= prev_page;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.upd && !ctl.hit && !ctl.evict) begin
			valid_q <= valid_q | prev_valid;
		end
	end

	assign page  = page_q;
	assign valid = valid_q;

endmodule

>>> sv/lru_page_reference_stack.sv
// LRU page reference stack: top level with handshake, capacity register and cell row.
// Throughput one reference per cycle while results are taken; a held, untaken result drops in_ready.
// The cell row compares and shifts in the accepting cycle; one result register decouples.
// Reset (arst_n low, asynchronous): stack empty, held count zero, capacity 8, no result held.
// Depends on lrps_pkg and lrps_cell.
module lru_page_reference_stack import lrps_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CAP_BITS-1:0]  cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [PAGE_BITS-1:0] page,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 hit,
	output logic                 evicted,
	output logic [PAGE_BITS-1:0] evicted_page,
	output logic [OCC_BITS-1:0]  occupancy
);

	logic [CAP_BITS-1:0]  capacity_q;
	logic [CNT_BITS-1:0]  held_q;
	logic                 out_valid_q;
	logic                 hit_q;
	logic                 evicted_q;
	logic [PAGE_BITS-1:0] evicted_page_q;
	logic [OCC_BITS-1:0]  occupancy_q;

	// cell row wiring; index i feeds cell i, i+1 comes out of it
	logic [PAGE_BITS-1:0] page_w  [DEPTH+1];
	logic                 valid_w [DEPTH+2];
	logic                 match_w [DEPTH+1];
	logic [PAGE_BITS-1:0] tail_w  [DEPTH];

	logic                 accept;
	logic                 any_hit;
	logic                 evict;
	logic [CMP_BITS-1:0]  eff_cap;
	logic [PAGE_BITS-1:0] tail_page;
	logic [CNT_BITS-1:0]  held_next;
	cell_ctl_t            ctl;

	// output register frees up when the result is taken
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// capacity zero behaves as one, anything above the row length as the row length
	always_comb begin
		if (capacity_q == '0) begin
			eff_cap = CMP_BITS'(1);
		end else if (CMP_BITS'(capacity_q) > CMP_BITS'(DEPTH)) begin
			eff_cap = CMP_BITS'(DEPTH);
		end else begin
			eff_cap = CMP_BITS'(capacity_q);
		end
	end

	assign any_hit = match_w[DEPTH];
	// held_q >= eff_cap with eff_cap >= 1 also implies a non-empty stack
	assign evict   = !any_hit && (CMP_BITS'(held_q) >= eff_cap);

	assign ctl.upd   = accept;
	assign ctl.hit   = any_hit;
	assign ctl.evict = evict;

	// head of the row: the new page enters cell 0, which always counts as following a valid slot
	assign page_w[0]        = page;
	assign valid_w[0]       = 1'b1;
	assign match_w[0]       = 1'b0;
	assign valid_w[DEPTH+1] = 1'b0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		lrps_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.key        (page),
			.prev_page  (page_w[i]),
			.prev_valid (valid_w[i]),
			.match_in   (match_w[i]),
			.next_valid (valid_w[i+2]),
			.page       (page_w[i+1]),
			.valid      (valid_w[i+1]),
			.match_out  (match_w[i+1]),
			.tail_page  (tail_w[i])
		);
	end

	// only one cell is the last valid one, so an OR collects its page
	always_comb begin
		tail_page = '0;
		for (int i = 0; i < DEPTH; i++) begin
			tail_page = tail_page | tail_w[i];
		end
	end

	assign held_next = (any_hit || evict) ? held_q : held_q + CNT_BITS'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= CAP_RESET;
			held_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
			end
			if (accept) begin
				held_q <= held_next;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result beat payload
	always_ff @(posedge clk) begin
		if (accept) begin
			hit_q          <= any_hit;
			evicted_q      <= evict;
			evicted_page_q <= evict ? tail_page : '0;
			occupancy_q    <= OCC_BITS'(held_next);
		end
	end

	assign out_valid    = out_valid_q;
	assign hit          = hit_q;
	assign evicted      = evicted_q;
	assign evicted_page = evicted_page_q;
	assign occupancy    = occupancy_q;

endmodule

>>> tb/tb_top.sv
// Self-checking bench for lru_page_reference_stack: recency-order predictor, scoreboard,
// directed and random page streams over several capacities and idle/stall mixes.
// Depends on lrps_pkg and the lru_page_reference_stack RTL.
`timescale 1ns / 100ps

module tb_top;
	import lrps_pkg::*;

	// one result beat as the block presents it
	typedef struct packed {
		logic                 hit;
		logic                 evicted;
		logic [PAGE_BITS-1:0] evicted_page;
		logic [OCC_BITS-1:0]  occupancy;
	} lru_result_t;

	localparam int MAX_REPORTS = 100;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CAP_BITS-1:0]  cfg_wdata = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [PAGE_BITS-1:0] page = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 hit;
	logic                 evicted;
	logic [PAGE_BITS-1:0] evicted_page;
	logic [OCC_BITS-1:0]  occupancy;

	// predictor state: slot 0 most recent, slot held-1 least recent
	logic [PAGE_BITS-1:0] lru_pages[DEPTH];
	int                   lru_held = 0;
	logic [CAP_BITS-1:0]  capacity_shadow = CAP_RESET;

	lru_result_t          pending_results[$];
	lru_result_t          oldest_result;
	int                   mismatch_count = 0;

	// traffic shaping: idle and stall percentages per cycle, and a counted result hold-off
	int                   send_idle_pct = 0;
	int                   ready_stall_pct = 0;
	int                   hold_off_req = 0;
	int                   hold_off_left = 0;

	lru_page_reference_stack dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.page         (page),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.hit          (hit),
		.evicted      (evicted),
		.evicted_page (evicted_page),
		.occupancy    (occupancy)
	);

	always #1 clk = ~clk;

	// Capacity 0 behaves as 1, anything above DEPTH as DEPTH. A miss with the
	// stack at or over capacity drops exactly one page (the least recent), so
	// occupancy never falls even when capacity is lowered beneath it.
	function automatic lru_result_t predict_reference(input logic [PAGE_BITS-1:0] pg);
		lru_result_t r;
		int          eff;
		int          pos;
		int          last;
		bit          found;
		r = '0;
		found = 1'b0;
		pos = 0;
		eff = (capacity_shadow == 0) ? 1 :
			((capacity_shadow > DEPTH) ? DEPTH : int'(capacity_shadow));
		for (int i = 0; i < lru_held; i++) begin
			if (!found && lru_pages[i] == pg) begin
				found = 1'b1;
				pos = i;
			end
		end
		if (found) begin
			r.hit = 1'b1;
			last = pos;
		end else if (lru_held >= eff && lru_held > 0) begin
			r.evicted = 1'b1;
			r.evicted_page = lru_pages[lru_held-1];
			last = lru_held - 1;
		end else begin
			last = lru_held;
			lru_held++;
		end
		for (int j = last; j > 0; j--)
			lru_pages[j] = lru_pages[j-1];
		lru_pages[0] = pg;
		r.occupancy = OCC_BITS'(lru_held);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint unsigned want_v,
			input longint unsigned got_v);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%0t ns: mismatch on %s: expected %0h, got %0h", $time, what,
				want_v, got_v);
	endtask

	// Offer one page; valid stays up across back-to-back beats and only drops
	// when a gap is drawn or the stream is drained.
	task automatic send_reference(input logic [PAGE_BITS-1:0] pg);
		lru_result_t res;
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		page <= pg;
		do @(posedge clk); while (!in_ready);
		res = predict_reference(pg);
		pending_results.push_back(res);
	endtask

	// Stop offering, let every pending beat come back, then idle past the
	// result stage before touching configuration.
	task automatic wait_results_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_BITS-1:0] v);
		wait_results_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		capacity_shadow = v;
	endtask

	// Straight after reset: capacity 0 must act as 1, then capacity 1 proper.
	task automatic test_min_capacity();
		send_idle_pct = 0;
		ready_stall_pct = 0;
		write_capacity(4'd0);
		send_reference(16'h0007);
		send_reference(16'h0007);
		send_reference(16'h0009);
		write_capacity(4'd1);
		send_reference(16'h0000);
		send_reference(16'hFFFF);
	endtask

	// Capacity above DEPTH, page extremes, hit at the front and at the back,
	// then misses on a full stack.
	task automatic test_directed_fill();
		send_idle_pct = 0;
		ready_stall_pct = 0;
		write_capacity(4'd15);
		send_reference(16'h0000);
		send_reference(16'hFFFF);
		send_reference(16'hFFFF);
		send_reference(16'h5A5A);
		send_reference(16'hA5A5);
		send_reference(lru_pages[lru_held-1]);
		send_reference(16'h5555);
		send_reference(16'hAAAA);
		send_reference(16'h8000);
		send_reference(16'h0001);
	endtask

	// Capacity dropped below what is held: occupancy must stay put.
	task automatic test_lowered_capacity();
		send_idle_pct = 0;
		ready_stall_pct = 0;
		write_capacity(4'd3);
		send_reference(16'h1357);
		send_reference(16'h1357);
		send_reference(16'h2468);
		send_reference(lru_pages[lru_held-1]);
	endtask

	// Receiver goes quiet for a long stretch while the sender keeps pushing,
	// so the result stage fills and in_ready has to drop.
	task automatic test_input_backpressure();
		send_idle_pct = 0;
		ready_stall_pct = 0;
		wait_results_drained();
		hold_off_req = 60;
		for (int i = 0; i < 20; i++)
			send_reference(PAGE_BITS'(16'h4000 + (i % 6)));
		wait_results_drained();
	endtask

	// Mostly a small hot set so hits and evictions both happen often, some
	// immediate repeats, and a share of fully random pages for bit coverage.
	task automatic test_random_traffic(input int idle_pct, input int stall_pct,
			input int n_items, input logic [CAP_BITS-1:0] cap);
		logic [PAGE_BITS-1:0] hot_pages[10];
		logic [PAGE_BITS-1:0] last_pg;
		logic [PAGE_BITS-1:0] pg;
		int                   sel;
		write_capacity(cap);
		send_idle_pct = idle_pct;
		ready_stall_pct = stall_pct;
		foreach (hot_pages[i])
			hot_pages[i] = PAGE_BITS'($urandom);
		last_pg = hot_pages[0];
		repeat (n_items) begin
			sel = $urandom_range(99);
			if (sel < 65)
				pg = hot_pages[$urandom_range(9)];
			else if (sel < 80)
				pg = last_pg;
			else
				pg = PAGE_BITS'($urandom);
			send_reference(pg);
			last_pg = pg;
		end
		wait_results_drained();
	endtask

	// result side: random stalls, or a counted hold-off when one is requested
	always @(posedge clk) begin
		if (hold_off_req > 0) begin
			hold_off_left = hold_off_req;
			hold_off_req = 0;
		end
		if (hold_off_left > 0) begin
			hold_off_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= ready_stall_pct);
		end
	end

	// scoreboard: every result beat against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result beat with nothing pending", 0, 0);
			end else begin
				oldest_result = pending_results.pop_front();
				if (hit !== oldest_result.hit)
					report_mismatch("hit", oldest_result.hit, hit);
				if (evicted !== oldest_result.evicted)
					report_mismatch("evicted", oldest_result.evicted, evicted);
				if (evicted_page !== oldest_result.evicted_page)
					report_mismatch("evicted_page", oldest_result.evicted_page,
						evicted_page);
				if (occupancy !== oldest_result.occupancy)
					report_mismatch("occupancy", oldest_result.occupancy, occupancy);
			end
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_min_capacity();
		test_random_traffic(0, 0, 150, 4'd2);
		test_random_traffic(76, 0, 150, 4'd4);
		test_random_traffic(0, 76, 150, 4'd6);
		test_directed_fill();
		test_lowered_capacity();
		test_input_backpressure();
		test_random_traffic(18, 18, 150, 4'd8);
		test_random_traffic(0, 0, 100, CAP_BITS'($urandom_range(15)));
		test_random_traffic(18, 18, 100, CAP_BITS'($urandom_range(15)));

		wait_results_drained();
		repeat (4) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#400000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

>>> files.f
sv/lrps_pkg.sv
sv/lrps_cell.sv
sv/lru_page_reference_stack.sv
tb/tb_top.sv
